>>> rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: action and status
// codes, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Width of the external word ports.
  localparam int unsigned PortWidth = 32;

  // Action codes carried by an input word. Code 7 is unused and does nothing.
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_CLEAR      = 3'd6
  } action_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input word and update the pointers
    logic load_read;  // capture the memory read data into the result
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read; // the offered action reads an entry from the memory
  } dq_stat_t;

endpackage

>>> rtl/core/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue kept in a ring buffer with a front index and an
// entry count. Each input word names one action and yields one result word.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+-----------------------------------
//   input   | in_valid_i / in_ready_o   | action_i, push_value_i
//   output  | out_valid_o / out_ready_i | read_value_o, status_o,
//           |                           | empty_o, entry_count_o
//
// One word is in flight at a time: a new word is taken only once the last
// result is delivered. Pops and peeks pass through a read state for the
// registered read of the entry memory; pushes, clears and failed reads do
// not. A stalled output holds the result and keeps the input closed. Reset
// empties the queue at once; the entry memory is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   action_i,
  input  logic signed [PortWidth-1:0]  push_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [PortWidth-1:0]  read_value_o,
  output logic [1:0]                   status_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   entry_count_o
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // Sequencing of accept, memory read and result delivery.
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Pointers, entry memory and result registers.
  dq_datapath #(
    .Depth     (DEPTH),
    .DataWidth (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .push_value_i  (push_value_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .empty_o       (empty_o),
    .entry_count_o (entry_count_o)
  );

endmodule

>>> rtl/core/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Controller for the double-ended queue. It takes one word at a time, goes
// through a read state for the memory when the action reads an entry, and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dq_stat_t stat_i,
  output dq_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    in_ready_d       = in_ready_q;
    out_valid_d      = out_valid_q;
    cmd_o.accept     = 1'b0;
    cmd_o.load_read  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          in_ready_d   = 1'b0;
          if (stat_i.needs_read) begin
            state_d = S_READ;
          end else begin
            state_d     = S_RESP;
            out_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd_o.load_read = 1'b1;
        state_d         = S_RESP;
        out_valid_d     = 1'b1;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
          in_ready_d  = 1'b1;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
        in_ready_d  = 1'b1;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Datapath of the double-ended queue: front index and count registers, the
// entry memory, and the result registers.
// ----------------------------------------------------------------------------
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned Depth     = 16,
  parameter int unsigned DataWidth = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dq_cmd_t                       cmd_i,
  output dq_stat_t                      stat_o,
  input  logic [2:0]                    action_i,
  input  logic signed [PortWidth-1:0]   push_value_i,
  output logic signed [PortWidth-1:0]   read_value_o,
  output logic [1:0]                    status_o,
  output logic                          empty_o,
  output logic [$clog2(Depth+1)-1:0]    entry_count_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = IdxW + 1;

  logic [IdxW-1:0]              front_q, front_d;
  logic [CntW-1:0]              count_q, count_d;
  logic signed [PortWidth-1:0]  value_q;
  status_e                      status_q, status_d;

  action_e                      action;
  logic                         is_push, is_read, none_held, is_full;
  logic [IdxW-1:0]              prev_front, next_front, back_pos, tail_pos;
  logic [SumW-1:0]              back_sum, tail_sum;
  logic                         we, re;
  logic [IdxW-1:0]              waddr, raddr;
  logic signed [63:0]           push_ext, read_ext;
  logic signed [DataWidth-1:0]  rdata;

  // Action decode and occupancy checks.
  assign action    = action_e'(action_i);
  assign is_push   = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK);
  assign is_read   = (action == ACT_POP_FRONT) || (action == ACT_POP_BACK) ||
                     (action == ACT_PEEK_FRONT) || (action == ACT_PEEK_BACK);
  assign none_held = (count_q == '0);
  assign is_full   = (count_q == CntW'(Depth));

  // Ring positions around the front index, wrapped at the depth.
  assign prev_front = (front_q == '0) ? IdxW'(Depth - 1) : front_q - 1'b1;
  assign next_front = (front_q == IdxW'(Depth - 1)) ? '0 : front_q + 1'b1;
  assign back_sum   = SumW'(front_q) + SumW'(count_q);
  assign tail_sum   = back_sum - 1'b1;
  assign back_pos   = (back_sum >= SumW'(Depth)) ? IdxW'(back_sum - SumW'(Depth))
                                                 : IdxW'(back_sum);
  assign tail_pos   = (tail_sum >= SumW'(Depth)) ? IdxW'(tail_sum - SumW'(Depth))
                                                 : IdxW'(tail_sum);

  assign stat_o.needs_read = is_read && !none_held;

  // Pointer update, memory access and status for the offered word.
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = status_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = back_pos;
    raddr    = front_q;
    if (cmd_i.accept) begin
      status_d = ST_OK;
      if (is_read && none_held) begin
        status_d = ST_EMPTY;
      end else if (is_push && is_full) begin
        status_d = ST_FULL;
      end else begin
        case (action)
          ACT_PUSH_FRONT: begin
            front_d = prev_front;
            waddr   = prev_front;
            we      = 1'b1;
            count_d = count_q + 1'b1;
          end
          ACT_PUSH_BACK: begin
            waddr   = back_pos;
            we      = 1'b1;
            count_d = count_q + 1'b1;
          end
          ACT_POP_FRONT: begin
            raddr   = front_q;
            re      = 1'b1;
            front_d = next_front;
            count_d = count_q - 1'b1;
          end
          ACT_POP_BACK: begin
            raddr   = tail_pos;
            re      = 1'b1;
            count_d = count_q - 1'b1;
          end
          ACT_PEEK_FRONT: begin
            raddr = front_q;
            re    = 1'b1;
          end
          ACT_PEEK_BACK: begin
            raddr = tail_pos;
            re    = 1'b1;
          end
          ACT_CLEAR: begin
            front_d = '0;
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Words are stored at the configured width and sign-extended on the way out.
  assign push_ext = 64'(push_value_i);
  assign read_ext = 64'(rdata);

  dq_ram #(
    .Width (DataWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (push_ext[DataWidth-1:0]),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Pointer and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Result word: cleared on accept, loaded from memory when a read completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= '0;
    end else if (cmd_i.load_read) begin
      value_q <= read_ext[PortWidth-1:0];
    end
  end

  assign read_value_o  = value_q;
  assign status_o      = status_q;
  assign empty_o       = none_held;
  assign entry_count_o = count_q;

endmodule
